// ===== design/rhls_pkg.sv =====
// ----------------------------------------------------------------------------
// rhls_pkg
// Shared types and constants for the RGB to weighted HLS converter.
// ----------------------------------------------------------------------------
package rhls_pkg;

  localparam int CHAN_W     = 16;  // channel bits
  localparam int WEIGHT_W   = 17;  // Q1.16 weight, 65536 = 1.0
  localparam int HUE_W      = 19;  // Q3.16 hue
  localparam int Q16_W      = 17;  // Q0.16 fraction up to 1.0
  localparam int DEN_W      = 16;  // divisor and partial remainder
  localparam int QUO_W      = 17;  // quotient bits, one per divider stage
  localparam int DIV_STAGES = QUO_W;
  localparam int PROD_W     = Q16_W + WEIGHT_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int IDX_W      = 2;

  localparam logic [Q16_W-1:0]    ONE_Q16  = 17'd65536;
  localparam logic [CHAN_W-1:0]   CHAN_MAX = 16'hFFFF;
  localparam logic [CHAN_W-1:0]   VAL_MAX  = 16'hFFFF;

  // register indexes and reset values
  localparam logic [IDX_W-1:0]    REG_RED_WEIGHT   = 2'd0;
  localparam logic [IDX_W-1:0]    REG_GREEN_WEIGHT = 2'd1;
  localparam logic [IDX_W-1:0]    REG_BLUE_WEIGHT  = 2'd2;
  localparam logic [WEIGHT_W-1:0] RED_WEIGHT_RST   = 17'd24248;
  localparam logic [WEIGHT_W-1:0] GREEN_WEIGHT_RST = 17'd28180;
  localparam logic [WEIGHT_W-1:0] BLUE_WEIGHT_RST  = 17'd13107;

  // sextant bases of the hue, in whole sextants
  localparam logic [2:0] SEXT_RED   = 3'd0;
  localparam logic [2:0] SEXT_GREEN = 3'd2;
  localparam logic [2:0] SEXT_BLUE  = 3'd4;
  localparam logic [2:0] SEXT_WRAP  = 3'd6;

  // cone saturation cases
  localparam logic [1:0] CONE_ZERO = 2'd0;
  localparam logic [1:0] CONE_PASS = 2'd1;
  localparam logic [1:0] CONE_SAT  = 2'd2;
  localparam logic [1:0] CONE_DIV  = 2'd3;

  // sideband along the first divider
  typedef struct packed {
    logic [CHAN_W-1:0] hi;
    logic [2:0]        base;
    logic              sub;
    logic [CHAN_W-1:0] wsum;
  } side1_t;

  // sideband along the second divider
  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [Q16_W-1:0]  sat;
    logic [1:0]        mode;
    logic [CHAN_W-1:0] wsum;
  } side2_t;

endpackage

// ===== design/rgb_to_weighted_hls_unit.sv =====
// ----------------------------------------------------------------------------
// rgb_to_weighted_hls_unit
// RGB pixel to hue, cone saturation and weighted lightness.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+-------------------------------
//   in      | input     | in_valid/in_stall | red, green, blue
//   out     | output    | out_valid/out_stall| hue, cone_saturation,
//           |           |                   | weighted_value
//   cfg     | input     | cfg_write         | cfg_index, cfg_data
//
// One pixel per clock while not stalled: sort and multiply, 17 stages of the
// hue and saturation dividers, cone case select, 17 stages of the cone
// divider, output register. rst is synchronous and clears the valid bits and
// restores the default weights. The pipeline holds only while its last stage
// is full and the output request is stalled; then every stage holds.
// ----------------------------------------------------------------------------
module rgb_to_weighted_hls_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rhls_pkg::CHAN_W-1:0]     red,
  input  logic [rhls_pkg::CHAN_W-1:0]     green,
  input  logic [rhls_pkg::CHAN_W-1:0]     blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rhls_pkg::HUE_W-1:0]      hue,
  output logic [rhls_pkg::Q16_W-1:0]      cone_saturation,
  output logic [rhls_pkg::CHAN_W-1:0]     weighted_value,
  input  logic                            cfg_write,
  input  logic [rhls_pkg::IDX_W-1:0]      cfg_index,
  input  logic [rhls_pkg::WEIGHT_W-1:0]   cfg_data
);
  import rhls_pkg::*;

  logic                en;
  logic [WEIGHT_W-1:0] red_weight, green_weight, blue_weight;

  // weight registers
  always_ff @(posedge clk) begin
    if (rst) begin
      red_weight   <= RED_WEIGHT_RST;
      green_weight <= GREEN_WEIGHT_RST;
      blue_weight  <= BLUE_WEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RED_WEIGHT:   red_weight   <= cfg_data;
        REG_GREEN_WEIGHT: green_weight <= cfg_data;
        REG_BLUE_WEIGHT:  blue_weight  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage A: sort channels, scale and weight ----
  logic [CHAN_W-1:0] s_hi, s_mid, s_lo;
  logic [2:0]        s_base;
  logic              s_sub;
  logic [Q16_W-1:0]  qr, qg, qb;

  always_comb begin
    s_hi = red; s_mid = green; s_lo = blue; s_base = SEXT_RED; s_sub = 1'b0;
    if (red >= green) begin
      if (red >= blue) begin
        if (green >= blue) begin
          s_hi = red; s_mid = green; s_lo = blue; s_base = SEXT_RED; s_sub = 1'b0;
        end else begin
          s_hi = red; s_mid = blue; s_lo = green; s_base = SEXT_WRAP; s_sub = 1'b1;
        end
      end else begin
        s_hi = blue; s_mid = red; s_lo = green; s_base = SEXT_BLUE; s_sub = 1'b0;
      end
    end else if (green >= blue) begin
      if (red >= blue) begin
        s_hi = green; s_mid = red; s_lo = blue; s_base = SEXT_GREEN; s_sub = 1'b1;
      end else begin
        s_hi = green; s_mid = blue; s_lo = red; s_base = SEXT_GREEN; s_sub = 1'b0;
      end
    end else begin
      s_hi = blue; s_mid = green; s_lo = red; s_base = SEXT_BLUE; s_sub = 1'b1;
    end
  end

  // c * 65536 / 65535 is c, except full scale maps to 1.0
  assign qr = (red   == CHAN_MAX) ? ONE_Q16 : {1'b0, red};
  assign qg = (green == CHAN_MAX) ? ONE_Q16 : {1'b0, green};
  assign qb = (blue  == CHAN_MAX) ? ONE_Q16 : {1'b0, blue};

  logic              va;
  logic [CHAN_W-1:0] a_num, a_den, a_hi;
  logic [2:0]        a_base;
  logic              a_sub;
  logic [PROD_W-1:0] a_pr, a_pg, a_pb;

  always_ff @(posedge clk) begin
    if (en) begin
      a_num  <= s_mid - s_lo;
      a_den  <= s_hi - s_lo;
      a_hi   <= s_hi;
      a_base <= s_base;
      a_sub  <= s_sub;
      a_pr   <= qr * red_weight;
      a_pg   <= qg * green_weight;
      a_pb   <= qb * blue_weight;
    end
  end

  // weighted sum, saturated
  logic [SUM_W-1:0]  wsum_full;
  logic [CHAN_W-1:0] wsum;
  assign wsum_full = {2'b0, a_pr} + {2'b0, a_pg} + {2'b0, a_pb};
  assign wsum = (wsum_full[SUM_W-1:2*CHAN_W] != '0) ? VAL_MAX
              : wsum_full[2*CHAN_W-1:CHAN_W];

  // ---- hue fraction and saturation dividers ----
  logic [DEN_W-1:0] hue_den, sat_den;
  logic [QUO_W-1:0] hue_q, sat_q;
  assign hue_den = (a_den == '0) ? DEN_W'(1) : a_den;
  assign sat_den = (a_hi  == '0) ? DEN_W'(1) : a_hi;

  rhls_div u_hue_div (
    .clk(clk), .en(en),
    .rem_in({1'b0, a_num[CHAN_W-1:1]}),
    .bits_in({a_num[0], {(QUO_W-1){1'b0}}}),
    .den_in(hue_den),
    .quo(hue_q)
  );

  rhls_div u_sat_div (
    .clk(clk), .en(en),
    .rem_in({1'b0, a_den[CHAN_W-1:1]}),
    .bits_in({a_den[0], {(QUO_W-1){1'b0}}}),
    .den_in(sat_den),
    .quo(sat_q)
  );

  side1_t sb1 [0:DIV_STAGES];
  logic   v1  [0:DIV_STAGES];
  assign sb1[0] = '{hi: a_hi, base: a_base, sub: a_sub, wsum: wsum};
  assign v1[0]  = va;

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_line1
    always_ff @(posedge clk) begin
      if (rst) v1[k] <= 1'b0;
      else if (en) v1[k] <= v1[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) sb1[k] <= sb1[k-1];
    end
  end

  // ---- stage P: assemble hue, pick cone case ----
  side1_t                 t1;
  logic [HUE_W-1:0]       hue_c;
  logic [Q16_W-1:0]       v_q;
  logic signed [Q16_W:0]  imv2;
  logic [Q16_W:0]         den_c;
  logic [1:0]             mode_c;

  assign t1 = sb1[DIV_STAGES];

  always_comb begin
    if (t1.sub) hue_c = {t1.base, {CHAN_W{1'b0}}} - {2'b0, hue_q};
    else        hue_c = {t1.base, {CHAN_W{1'b0}}} + {2'b0, hue_q};
    v_q   = (t1.hi == CHAN_MAX) ? ONE_Q16 : {1'b0, t1.hi};
    imv2  = $signed({1'b0, v_q}) - $signed({2'b0, sat_q[Q16_W-1:1]});
    den_c = {1'b0, ONE_Q16} - $unsigned(imv2);
    if (imv2 >= $signed({1'b0, ONE_Q16}))
      mode_c = CONE_ZERO;
    else if (imv2 <= $signed({2'b0, ONE_Q16[Q16_W-1:1]}))
      mode_c = CONE_PASS;
    else if ({1'b0, sat_q} >= {den_c[DEN_W-1:0], 2'b0})
      mode_c = CONE_SAT;
    else
      mode_c = CONE_DIV;
  end

  logic             vp;
  side2_t           p_side;
  logic [DEN_W-1:0] p_den;

  always_ff @(posedge clk) begin
    if (rst) vp <= 1'b0;
    else if (en) vp <= v1[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side <= '{hue: hue_c, sat: sat_q, mode: mode_c, wsum: t1.wsum};
      p_den  <= den_c[DEN_W-1:0];
    end
  end

  // ---- cone divider: s * 32768 / (1 - imv2) ----
  logic [DEN_W-1:0] cone_den;
  logic [QUO_W-1:0] cone_q;
  assign cone_den = (p_side.mode == CONE_DIV) ? p_den : DEN_W'(1);

  rhls_div u_cone_div (
    .clk(clk), .en(en),
    .rem_in({1'b0, p_side.sat[Q16_W-1:2]}),
    .bits_in({p_side.sat[1:0], {(QUO_W-2){1'b0}}}),
    .den_in(cone_den),
    .quo(cone_q)
  );

  side2_t sb2 [0:DIV_STAGES];
  logic   v2  [0:DIV_STAGES];
  assign sb2[0] = p_side;
  assign v2[0]  = vp;

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_line2
    always_ff @(posedge clk) begin
      if (rst) v2[k] <= 1'b0;
      else if (en) v2[k] <= v2[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) sb2[k] <= sb2[k-1];
    end
  end

  // ---- final cone value ----
  side2_t           t2;
  logic [Q16_W-1:0] cone_c;
  assign t2 = sb2[DIV_STAGES];

  always_comb begin
    case (t2.mode)
      CONE_ZERO: cone_c = '0;
      CONE_PASS: cone_c = t2.sat;
      CONE_SAT:  cone_c = ONE_Q16;
      CONE_DIV:  cone_c = (cone_q > ONE_Q16) ? ONE_Q16 : cone_q;
      default:   cone_c = '0;
    endcase
  end

  // ---- flow control and output register ----
  logic out_load;
  assign out_load = !out_valid || !out_stall;
  assign en       = out_load || !v2[DIV_STAGES];
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (out_load) out_valid <= v2[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    if (out_load && v2[DIV_STAGES]) begin
      hue             <= t2.hue;
      cone_saturation <= cone_c;
      weighted_value  <= t2.wsum;
    end
  end

`ifndef SYNTHESIS
  a_cone_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cone_saturation <= ONE_Q16)
    else $error("cone saturation above 1.0");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < {SEXT_WRAP, {CHAN_W{1'b0}}})
    else $error("hue outside six sextants");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && v2[DIV_STAGES]))
    else $error("input stalled without output back-pressure");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    (v2[DIV_STAGES] && out_valid && out_stall) |=> v2[DIV_STAGES])
    else $error("finished item lost under stall");
`endif

endmodule

// ===== design/rhls_div.sv =====
// ----------------------------------------------------------------------------
// rhls_div
// Pipelined restoring divider, one quotient bit per stage.
// The caller supplies the upper dividend part as a start remainder below the
// divisor and the remaining low dividend bits, MSB first.
// ----------------------------------------------------------------------------
module rhls_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [rhls_pkg::DEN_W-1:0]  rem_in,
  input  logic [rhls_pkg::QUO_W-1:0]  bits_in,
  input  logic [rhls_pkg::DEN_W-1:0]  den_in,
  output logic [rhls_pkg::QUO_W-1:0]  quo
);
  import rhls_pkg::*;

  logic [DEN_W-1:0] rem   [0:DIV_STAGES];
  logic [QUO_W-1:0] bits  [0:DIV_STAGES];
  logic [DEN_W-1:0] den   [0:DIV_STAGES];
  logic [QUO_W-1:0] quo_s [0:DIV_STAGES];
  logic [DEN_W:0]   trial [0:DIV_STAGES-1];
  logic [DEN_W:0]   diff  [0:DIV_STAGES-1];
  logic             ge    [0:DIV_STAGES-1];

  assign rem[0]   = rem_in;
  assign bits[0]  = bits_in;
  assign den[0]   = den_in;
  assign quo_s[0] = '0;

  // one trial subtract per stage
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    assign trial[k] = {rem[k], bits[k][QUO_W-1]};
    assign diff[k]  = trial[k] - {1'b0, den[k]};
    assign ge[k]    = (trial[k] >= {1'b0, den[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]   <= ge[k] ? diff[k][DEN_W-1:0] : trial[k][DEN_W-1:0];
        bits[k+1]  <= {bits[k][QUO_W-2:0], 1'b0};
        den[k+1]   <= den[k];
        quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge[k]};
      end
    end
  end

  assign quo = quo_s[DIV_STAGES];

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Checks rgb_to_weighted_hls_unit against its own predictor of hue, cone
// saturation and weighted value. A directed table covers the primaries, grey,
// black, white, ties and cone cases. Random pixels follow under several weight
// settings, with random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rhls_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int LIMIT      = 300000;
  localparam int HOLD_LEN   = 400;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [Q16_W-1:0]  cone;
    logic [CHAN_W-1:0] wv;
  } hls_res_t;

  typedef struct packed {
    logic [CHAN_W-1:0] r, g, b;
    logic              typed;
    hls_res_t          res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CHAN_W-1:0] red = '0, green = '0, blue = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [HUE_W-1:0] hue;
  logic [Q16_W-1:0] cone_saturation;
  logic [CHAN_W-1:0] weighted_value;
  logic cfg_write = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  rgb_to_weighted_hls_unit dut (.*);

  // weights as the predictor sees them
  logic [WEIGHT_W-1:0] wt_red, wt_green, wt_blue;
  hls_res_t pending_pixels[$];
  int errors = 0, n_sent = 0, n_checked = 0, n_phases = 0;
  int cycles = 0;
  bit quiet = 0;      // no idling anywhere
  bit hold_req = 0;

  initial forever #1 clk = ~clk;

  // channel to Q0.16
  function automatic longint unsigned to_q16(input logic [CHAN_W-1:0] c);
    return ({48'd0, c} << 16) / 64'd65535;
  endfunction

  function automatic longint unsigned frac16(input longint unsigned n, d);
    return (n << 16) / d;
  endfunction

  function automatic hls_res_t predict_hls(input logic [CHAN_W-1:0] r, g, b);
    longint unsigned rr, gg, bb;
    longint unsigned hi, lo, h, s, v, cone, wsum;
    longint imv2;
    hls_res_t res;
    rr = {48'd0, r}; gg = {48'd0, g}; bb = {48'd0, b};
    // sextant select, ties resolved as red, then green
    if (rr >= gg) begin
      if (rr >= bb) begin
        if (gg >= bb) begin
          if (rr > bb) begin
            hi = rr; lo = bb; h = frac16(gg - bb, rr - bb);
          end else begin
            hi = rr; lo = rr; h = 0;
          end
        end else begin
          hi = rr; lo = gg; h = 6 * 65536 - frac16(bb - gg, rr - gg);
        end
      end else begin
        hi = bb; lo = gg; h = 4 * 65536 + frac16(rr - gg, bb - gg);
      end
    end else if (gg >= bb) begin
      if (rr >= bb) begin
        hi = gg; lo = bb; h = 2 * 65536 - frac16(rr - bb, gg - bb);
      end else begin
        hi = gg; lo = rr; h = 2 * 65536 + frac16(bb - rr, gg - rr);
      end
    end else begin
      hi = bb; lo = rr; h = 4 * 65536 - frac16(gg - rr, bb - rr);
    end
    s = (hi > 0) ? frac16(hi - lo, hi) : 0;
    v = to_q16(hi[CHAN_W-1:0]);
    imv2 = longint'(v) - longint'(s >> 1);
    // cone cases: at or past white, lower half, upper half divide
    if (imv2 >= 65536) cone = 0;
    else if (imv2 <= 32768) cone = s;
    else begin
      cone = (s << 15) / longint'(65536 - imv2);
      if (cone > 65536) cone = 65536;
    end
    wsum = (to_q16(r) * wt_red + to_q16(g) * wt_green + to_q16(b) * wt_blue) >> 16;
    if (wsum > 65535) wsum = 65535;
    res.hue = h[HUE_W-1:0];
    res.cone = cone[Q16_W-1:0];
    res.wv = wsum[CHAN_W-1:0];
    return res;
  endfunction

  // offer one pixel, hold it until accepted, then maybe idle
  task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b, input bit typed,
                            input hls_res_t typed_res);
    red <= r; green <= g; blue <= b; in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_pixels.push_back(typed ? typed_res : predict_hls(r, g, b));
    n_sent++;
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic write_weights(input logic [WEIGHT_W-1:0] wr, wg, wb);
    // let the pipe drain before touching the weights
    in_valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (45) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_RED_WEIGHT; cfg_data <= wr;
    @(posedge clk);
    cfg_index <= REG_GREEN_WEIGHT; cfg_data <= wg;
    @(posedge clk);
    cfg_index <= REG_BLUE_WEIGHT; cfg_data <= wb;
    @(posedge clk);
    // unknown index must leave every weight alone
    cfg_index <= REG_UNUSED; cfg_data <= WEIGHT_W'($urandom_range(131071));
    @(posedge clk);
    cfg_write <= 1'b0;
    wt_red = wr; wt_green = wg; wt_blue = wb;
    n_phases++;
  endtask

  // random pixel with a bias toward greys, ties, full scale and tiny values
  task automatic random_pixel();
    logic [CHAN_W-1:0] r, g, b;
    int kind;
    r = CHAN_W'($urandom); g = CHAN_W'($urandom); b = CHAN_W'($urandom);
    kind = $urandom_range(9);
    case (kind)
      0: begin
        g = r; b = r;
      end
      1: g = r;
      2: b = g;
      3: begin
        r = CHAN_MAX; g = CHAN_W'($urandom_range(65535, 60000));
      end
      4: begin
        r = CHAN_W'($urandom_range(3)); g = CHAN_W'($urandom_range(3));
        b = CHAN_W'($urandom_range(3));
      end
      5: begin
        r = CHAN_MAX - CHAN_W'($urandom_range(2000));
        g = r - CHAN_W'($urandom_range(500));
        b = r - CHAN_W'($urandom_range(500));
      end
      default: ;
    endcase
    send_pixel(r, g, b, 1'b0, '0);
  endtask

  dir_row_t dir_rows [16];

  // stimulus
  initial begin
    wt_red = RED_WEIGHT_RST; wt_green = GREEN_WEIGHT_RST; wt_blue = BLUE_WEIGHT_RST;
    dir_rows = '{
      '{16'h0000, 16'h0000, 16'h0000, 1'b1, '{19'd0, 17'd0, 16'd0}},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '{19'd0, 17'd0, 16'd65535}},
      '{16'hFFFF, 16'h0000, 16'h0000, 1'b1, '{19'd0, 17'd65536, 16'd24248}},
      '{16'h0000, 16'hFFFF, 16'h0000, 1'b1, '{19'd131072, 17'd65536, 16'd28180}},
      '{16'h0000, 16'h0000, 16'hFFFF, 1'b1, '{19'd262144, 17'd65536, 16'd13107}},
      '{16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, '0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{16'hFFFF, 16'h0000, 16'h0001, 1'b0, '0},
      '{16'h0001, 16'h0000, 16'h0000, 1'b0, '0},
      '{16'h0000, 16'h0001, 16'h0002, 1'b0, '0},
      '{16'hFFFF, 16'h8000, 16'h8000, 1'b0, '0},
      '{16'hFFFF, 16'hFFFE, 16'hFFFE, 1'b0, '0},
      '{16'h4000, 16'h8000, 16'h2000, 1'b0, '0},
      '{16'h1234, 16'hFEDC, 16'h8001, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i])
      send_pixel(dir_rows[i].r, dir_rows[i].g, dir_rows[i].b, dir_rows[i].typed,
                 dir_rows[i].res);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_weights(RED_WEIGHT_RST, GREEN_WEIGHT_RST, BLUE_WEIGHT_RST);
        1: write_weights('0, '0, '0);
        2: write_weights(17'd65536, 17'd65536, 17'd65536);
        3: write_weights(17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        default: write_weights(WEIGHT_W'($urandom_range(131071)),
                               WEIGHT_W'($urandom_range(131071)),
                               WEIGHT_W'($urandom_range(131071)));
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        quiet = (ph == 1 && k >= 50 && k < 200);
        if (ph == 2 && k == 20) hold_req = 1;
        random_pixel();
      end
    end
    in_valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (50) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("results missing: %0d", pending_pixels.size());
      errors++;
    end
    $display("tb_top: %0d pixels sent, %0d results checked over %0d weight settings",
             n_sent, n_checked, n_phases);
    $display("tb_top: primaries, grey, black, white, ties, all cone cases, hold-off");
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  // result side: check each accepted request, drive stall
  initial begin
    hls_res_t exp_res;
    bit held;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_pixels.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_res = pending_pixels.pop_front();
          n_checked++;
          if (hue !== exp_res.hue) begin
            $error("hue: expected %0d, got %0d", exp_res.hue, hue); errors++;
          end
          if (cone_saturation !== exp_res.cone) begin
            $error("cone_saturation: expected %0d, got %0d", exp_res.cone,
                   cone_saturation); errors++;
          end
          if (weighted_value !== exp_res.wv) begin
            $error("weighted_value: expected %0d, got %0d", exp_res.wv,
                   weighted_value); errors++;
          end
        end
      end
      if (hold_req && !held) begin
        // long hold-off so the pipe fills and stalls the input
        held = 1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= (!quiet && $urandom_range(99) < 25);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
